[rtl/core/msc_pkg.sv]
// Shared constants, codes and the result type of the MOESI snooping cache controller.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

  // Default geometry
  localparam int DEF_SET_COUNT    = 64;
  localparam int DEF_WAY_COUNT    = 4;
  localparam int DEF_ADDRESS_BITS = 32;

  // Fixed field widths
  localparam int TAG_W    = 26;
  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 4;
  localparam int STATE_W  = 3;

  localparam logic [OFFSET_W-1:0] DEF_OFFSET_BITS = 4'd6;

  // Register index (byte address bit 2 of the config port)
  localparam logic REG_OFFSET_BITS = 1'b0;

  // Request kinds
  localparam logic [2:0] KIND_RD       = 3'd0;
  localparam logic [2:0] KIND_WR       = 3'd1;
  localparam logic [2:0] KIND_SNP_RD   = 3'd2;
  localparam logic [2:0] KIND_SNP_RDX  = 3'd3;
  localparam logic [2:0] KIND_SNP_UPGR = 3'd4;

  // Bus requests
  localparam logic [1:0] BUS_NONE = 2'd0;
  localparam logic [1:0] BUS_RD   = 2'd1;
  localparam logic [1:0] BUS_RDX  = 2'd2;
  localparam logic [1:0] BUS_UPGR = 2'd3;

  // Line states
  localparam logic [STATE_W-1:0] ST_I = 3'd0;
  localparam logic [STATE_W-1:0] ST_S = 3'd1;
  localparam logic [STATE_W-1:0] ST_E = 3'd2;
  localparam logic [STATE_W-1:0] ST_O = 3'd3;
  localparam logic [STATE_W-1:0] ST_M = 3'd4;

  typedef struct packed {
    logic               hit;
    logic [1:0]         bus_request;
    logic               writeback;
    logic [ADDR_W-1:0]  writeback_address;
    logic               flush;
    logic               copy_present;
    logic [STATE_W-1:0] prior_state;
    logic [STATE_W-1:0] next_state;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/moesi_snooping_cache_controller.sv]
// Top level of the MOESI snooping cache controller: control, config port and set memories.
`timescale 1ns / 1ps
`default_nettype none
// For each item the accepting edge reads the addressed set row from the tag and state
// memories (registered read data), and the next edge writes the updated row back and
// registers the result, which shows on the result ports with done_o high for one cycle. busy is
// high in the cycle between, so a new item may be accepted in the cycle its predecessor's
// result is shown, but not while one is in lookup. After reset the block clears every set
// row of the state memory (busy high, config writes taken). SET_COUNT must be a power of two;
// the block itself does not enforce it. Results cannot be stalled by the receiver.
module moesi_snooping_cache_controller #(
  parameter int SET_COUNT    = msc_pkg::DEF_SET_COUNT,
  parameter int WAY_COUNT    = msc_pkg::DEF_WAY_COUNT,
  parameter int ADDRESS_BITS = msc_pkg::DEF_ADDRESS_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // item request
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [2:0]                    kind_i,
  input  wire logic [msc_pkg::ADDR_W-1:0]    address_i,
  input  wire logic                          shared_seen_i,
  // result
  output      logic                          done_o,
  output      logic                          hit_o,
  output      logic [1:0]                    bus_request_o,
  output      logic                          writeback_o,
  output      logic [msc_pkg::ADDR_W-1:0]    writeback_address_o,
  output      logic                          flush_o,
  output      logic                          copy_present_o,
  output      logic [msc_pkg::STATE_W-1:0]   prior_state_o,
  output      logic [msc_pkg::STATE_W-1:0]   next_state_o,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);

  localparam int RankW   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int MetaW   = msc_pkg::STATE_W + RankW;
  localparam int SetBits = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
  localparam int SetIw   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam logic [msc_pkg::ADDR_W-1:0] SetMask = msc_pkg::ADDR_W'(SET_COUNT - 1);
  localparam logic [msc_pkg::ADDR_W-1:0] AddrMask =
    (ADDRESS_BITS >= msc_pkg::ADDR_W) ? '1 :
    msc_pkg::ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam logic [SetIw-1:0] LastSet = SetIw'(SET_COUNT - 1);

  // Control states
  localparam logic [1:0] CTL_CLEAR = 2'd0;
  localparam logic [1:0] CTL_IDLE  = 2'd1;
  localparam logic [1:0] CTL_LOOK  = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [SetIw-1:0]                clr_idx_q, clr_idx_d;
  logic [msc_pkg::OFFSET_W-1:0]    offset_q, offset_d;
  logic                            done_q;
  logic [2:0]                      kind_q;
  logic [msc_pkg::TAG_W-1:0]       tag_q;
  logic [msc_pkg::ADDR_W-1:0]      set_q;
  logic                            shared_q;
  msc_pkg::result_t                res_q;

  logic                            accept, cfg_wr;
  logic [msc_pkg::ADDR_W-1:0]      addr_m, block, set_in;
  logic [WAY_COUNT*msc_pkg::TAG_W-1:0] tag_rd, tag_wr;
  logic [WAY_COUNT*MetaW-1:0]      meta_rd, meta_upd, meta_init, meta_wr;
  logic                            tag_we_upd, tag_we, meta_we;
  logic [SetIw-1:0]                meta_waddr;
  msc_pkg::result_t                res_d;

  // Handshakes
  assign busy   = (state_q != CTL_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == msc_pkg::REG_OFFSET_BITS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == msc_pkg::REG_OFFSET_BITS) ? 32'(offset_q) : '0;

  // Split the request address
  assign addr_m = address_i & AddrMask;
  assign block  = addr_m >> offset_q;
  assign set_in = block & SetMask;

  // Reset image of a state row: all invalid, rank equals way
  always_comb begin
    meta_init = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      meta_init[w*MetaW + msc_pkg::STATE_W +: RankW] = RankW'(w);
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    offset_d  = cfg_wr ? pwdata[msc_pkg::OFFSET_W-1:0] : offset_q;
    case (state_q)
      CTL_CLEAR: begin
        clr_idx_d = clr_idx_q + SetIw'(1);
        if (clr_idx_q == LastSet) state_d = CTL_IDLE;
      end
      CTL_IDLE: begin
        if (accept) state_d = CTL_LOOK;
      end
      CTL_LOOK: begin
        state_d = CTL_IDLE;
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CTL_CLEAR;
      clr_idx_q <= '0;
      offset_q  <= msc_pkg::DEF_OFFSET_BITS;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      offset_q  <= offset_d;
      done_q    <= (state_q == CTL_LOOK);
    end
  end

  // Hold the accepted item and the finished result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      tag_q    <= msc_pkg::TAG_W'(block >> SetBits);
      set_q    <= set_in;
      shared_q <= shared_seen_i;
    end
    if (state_q == CTL_LOOK) begin
      res_q <= res_d;
    end
  end

  // Row update
  msc_line_update #(
    .WAY_COUNT (WAY_COUNT),
    .SET_COUNT (SET_COUNT)
  ) u_update (
    .kind_i     (kind_q),
    .tag_i      (tag_q),
    .set_i      (set_q),
    .shared_i   (shared_q),
    .offset_i   (offset_q),
    .tag_row_i  (tag_rd),
    .meta_row_i (meta_rd),
    .tag_row_o  (tag_wr),
    .meta_row_o (meta_upd),
    .tag_we_o   (tag_we_upd),
    .res_o      (res_d)
  );

  // Write back the row, or sweep the state memory after reset
  assign tag_we     = (state_q == CTL_LOOK) && tag_we_upd;
  assign meta_we    = (state_q == CTL_LOOK) || (state_q == CTL_CLEAR);
  assign meta_waddr = (state_q == CTL_CLEAR) ? clr_idx_q : set_q[SetIw-1:0];
  assign meta_wr    = (state_q == CTL_CLEAR) ? meta_init : meta_upd;

  msc_ram #(
    .WIDTH (WAY_COUNT * msc_pkg::TAG_W),
    .DEPTH (SET_COUNT)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q[SetIw-1:0]),
    .wdata_i (tag_wr),
    .raddr_i (set_in[SetIw-1:0]),
    .rdata_o (tag_rd)
  );

  msc_ram #(
    .WIDTH (WAY_COUNT * MetaW),
    .DEPTH (SET_COUNT)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wr),
    .raddr_i (set_in[SetIw-1:0]),
    .rdata_o (meta_rd)
  );

  // Drive result ports
  assign done_o              = done_q;
  assign hit_o               = res_q.hit;
  assign bus_request_o       = res_q.bus_request;
  assign writeback_o         = res_q.writeback;
  assign writeback_address_o = res_q.writeback_address;
  assign flush_o             = res_q.flush;
  assign copy_present_o      = res_q.copy_present;
  assign prior_state_o       = res_q.prior_state;
  assign next_state_o        = res_q.next_state;

`ifndef SYNTH
  a_done_after_look : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == CTL_LOOK))
    else $error("result strobe without a lookup cycle");

  a_accept_to_look : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == CTL_LOOK))
    else $error("accepted item did not enter lookup");

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CTL_CLEAR) |-> !accept && !done_q)
    else $error("item activity during clearing pass");

  a_wb_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && writeback_o) |-> (!hit_o && (bus_request_o != msc_pkg::BUS_NONE)))
    else $error("writeback without a processor miss");

  a_snoop_no_bus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && copy_present_o) |-> (hit_o && (bus_request_o == msc_pkg::BUS_NONE)))
    else $error("snoop result carries a bus request");
`endif

endmodule
`default_nettype wire

[rtl/core/msc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]                               wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output      logic [WIDTH-1:0]                               rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/core/msc_line_update.sv]
// Set row update: tag match, victim choice, MOESI transition and LRU reorder.
`timescale 1ns / 1ps
`default_nettype none
module msc_line_update #(
  parameter int WAY_COUNT = msc_pkg::DEF_WAY_COUNT,
  parameter int SET_COUNT = msc_pkg::DEF_SET_COUNT
) (
  input  wire logic [2:0]                          kind_i,
  input  wire logic [msc_pkg::TAG_W-1:0]           tag_i,
  input  wire logic [msc_pkg::ADDR_W-1:0]          set_i,
  input  wire logic                                shared_i,
  input  wire logic [msc_pkg::OFFSET_W-1:0]        offset_i,
  input  wire logic [WAY_COUNT*msc_pkg::TAG_W-1:0] tag_row_i,
  input  wire logic [WAY_COUNT*(msc_pkg::STATE_W +
                     ((WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1))-1:0] meta_row_i,
  output      logic [WAY_COUNT*msc_pkg::TAG_W-1:0] tag_row_o,
  output      logic [WAY_COUNT*(msc_pkg::STATE_W +
                     ((WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1))-1:0] meta_row_o,
  output      logic                                tag_we_o,
  output      msc_pkg::result_t                    res_o
);

  localparam int RankW   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int MetaW   = msc_pkg::STATE_W + RankW;
  localparam int SetBits = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
  localparam logic [RankW-1:0] OldestRank = RankW'(WAY_COUNT - 1);

  logic [msc_pkg::STATE_W-1:0] st [WAY_COUNT];
  logic [RankW-1:0]            rk [WAY_COUNT];
  logic [msc_pkg::TAG_W-1:0]   tg [WAY_COUNT];
  logic [WAY_COUNT-1:0]        match, inval, oldest;
  logic [RankW-1:0]            hit_way, inv_way, lru_way, vic_way, tgt_way;
  logic                        any_hit, is_proc, is_snoop;
  logic [msc_pkg::STATE_W-1:0] cur_st, new_st;
  logic [63:0]                 vblock, wb_full;

  // Unpack the set row
  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      st[w]     = meta_row_i[w*MetaW +: msc_pkg::STATE_W];
      rk[w]     = meta_row_i[w*MetaW + msc_pkg::STATE_W +: RankW];
      tg[w]     = tag_row_i[w*msc_pkg::TAG_W +: msc_pkg::TAG_W];
      match[w]  = (st[w] != msc_pkg::ST_I) && (tg[w] == tag_i);
      inval[w]  = (st[w] == msc_pkg::ST_I);
      oldest[w] = (rk[w] == OldestRank);
    end
  end

  // Pick lowest-numbered way of each kind
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (match[w])  hit_way = RankW'(w);
      if (inval[w])  inv_way = RankW'(w);
      if (oldest[w]) lru_way = RankW'(w);
    end
  end

  assign any_hit  = |match;
  assign is_proc  = (kind_i == msc_pkg::KIND_RD) || (kind_i == msc_pkg::KIND_WR);
  assign is_snoop = (kind_i == msc_pkg::KIND_SNP_RD) || (kind_i == msc_pkg::KIND_SNP_RDX) ||
                    (kind_i == msc_pkg::KIND_SNP_UPGR);
  assign vic_way  = (|inval) ? inv_way : lru_way;
  assign tgt_way  = (is_proc && !any_hit) ? vic_way : hit_way;
  assign cur_st   = st[tgt_way];

  // Victim block address
  assign vblock  = (64'(tg[tgt_way]) << SetBits) | 64'(set_i);
  assign wb_full = vblock << offset_i;

  // Coherence transition and row rewrite
  always_comb begin
    res_o      = '0;
    new_st     = cur_st;
    tag_row_o  = tag_row_i;
    meta_row_o = meta_row_i;
    tag_we_o   = 1'b0;
    if (is_proc) begin
      if (any_hit) begin
        res_o.hit         = 1'b1;
        res_o.prior_state = cur_st;
        if (kind_i == msc_pkg::KIND_WR) begin
          if ((cur_st == msc_pkg::ST_S) || (cur_st == msc_pkg::ST_O)) begin
            res_o.bus_request = msc_pkg::BUS_UPGR;
          end
          new_st = msc_pkg::ST_M;
        end
      end else begin
        if ((cur_st == msc_pkg::ST_M) || (cur_st == msc_pkg::ST_O)) begin
          res_o.writeback         = 1'b1;
          res_o.writeback_address = wb_full[msc_pkg::ADDR_W-1:0];
        end
        if (kind_i == msc_pkg::KIND_WR) begin
          res_o.bus_request = msc_pkg::BUS_RDX;
          new_st            = msc_pkg::ST_M;
        end else begin
          res_o.bus_request = msc_pkg::BUS_RD;
          new_st            = shared_i ? msc_pkg::ST_S : msc_pkg::ST_E;
        end
        tag_we_o = 1'b1;
        tag_row_o[tgt_way*msc_pkg::TAG_W +: msc_pkg::TAG_W] = tag_i;
      end
      res_o.next_state = new_st;
      // Move the touched way to the front of the LRU order
      for (int w = 0; w < WAY_COUNT; w++) begin
        if (RankW'(w) == tgt_way) begin
          meta_row_o[w*MetaW + msc_pkg::STATE_W +: RankW] = '0;
        end else if (rk[w] < rk[tgt_way]) begin
          meta_row_o[w*MetaW + msc_pkg::STATE_W +: RankW] = rk[w] + RankW'(1);
        end
      end
      meta_row_o[tgt_way*MetaW +: msc_pkg::STATE_W] = new_st;
    end else if (is_snoop && any_hit) begin
      res_o.hit          = 1'b1;
      res_o.copy_present = 1'b1;
      res_o.prior_state  = cur_st;
      case (kind_i)
        msc_pkg::KIND_SNP_RD: begin
          if (cur_st == msc_pkg::ST_M) begin
            new_st      = msc_pkg::ST_O;
            res_o.flush = 1'b1;
          end else if (cur_st == msc_pkg::ST_O) begin
            res_o.flush = 1'b1;
          end else if (cur_st == msc_pkg::ST_E) begin
            new_st = msc_pkg::ST_S;
          end
        end
        msc_pkg::KIND_SNP_RDX: begin
          res_o.flush = (cur_st == msc_pkg::ST_M) || (cur_st == msc_pkg::ST_O);
          new_st      = msc_pkg::ST_I;
        end
        default: begin
          new_st = msc_pkg::ST_I;
        end
      endcase
      res_o.next_state = new_st;
      meta_row_o[tgt_way*MetaW +: msc_pkg::STATE_W] = new_st;
    end
  end

endmodule
`default_nettype wire
